### sv/vtp_pkg.sv
// shared types, constants and helpers for the vertex transform block
package vtp_pkg;

  // widest rounded dot product over the supported fraction range
  localparam int DOT_W  = 59;
  // quotient bits kept by the divider: integer part, fraction and one rounding bit
  localparam int QUO_W  = 33;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int THR_W  = 17;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_POINT = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_DIVIDE_ENABLE       = 1'b0,
    CFG_NEAR_ZERO_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_near_zero;
  } out_item_t;

  // one classified point waiting for the divider
  typedef struct packed {
    logic                        do_div;
    logic                        near;
    logic [2:0]                  neg;
    logic [2:0][31:0]            plain;
    logic [2:0][DOT_W-1:0]       num;
    logic [DOT_W-1:0]            den;
  } qent_t;

  function automatic logic [31:0] sat_dot(input logic [DOT_W-1:0] v);
    logic fits;
    fits = (v[DOT_W-1:31] == '0) || (v[DOT_W-1:31] == '1);
    if (fits) return v[31:0];
    else if (v[DOT_W-1]) return SAT_MIN;
    else return SAT_MAX;
  endfunction

endpackage

### sv/vtp_front.sv
// front end: matrix store, products, rounded dot products and classification
module vtp_front
  import vtp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  in_item_t         item,
  input  logic             divide_enable,
  input  logic [THR_W-1:0] near_zero_threshold,
  input  logic             q_ready,
  output logic             q_push,
  output qent_t            q_data
);

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic signed [31:0] coef [16];
  logic               en;
  logic               accept;

  logic               v1, v2, v3;
  logic signed [63:0] prod [16];
  logic signed [64:0] pair [4][2];
  logic [DOT_W-1:0]   dot [4];

  logic signed [31:0] vec [4];
  logic signed [65:0] tot [4];
  logic signed [65:0] shf [4];
  logic [DOT_W-1:0]   mag [4];
  logic               near;

  assign en         = !v3 || q_ready;
  assign item_ready = en;
  assign accept     = item_valid && item_ready;
  assign q_push     = v3 && q_ready;

  assign vec[0] = item.in_x;
  assign vec[1] = item.in_y;
  assign vec[2] = item.in_z;
  assign vec[3] = item.in_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) coef[i] <= '0;
    end else if (accept && item.cmd == CMD_LOAD) begin
      coef[item.coef_index] <= item.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= accept && item.cmd == CMD_POINT;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // products read the matrix as it stands when the point is taken
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          prod[k*4+j] <= vec[k] * coef[k*4+j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        pair[j][0] <= 65'(prod[j]) + 65'(prod[4+j]);
        pair[j][1] <= 65'(prod[8+j]) + 65'(prod[12+j]);
      end
    end
  end

  // round to nearest, ties up
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      tot[j] = 66'(pair[j][0]) + 66'(pair[j][1]) + HALF;
      shf[j] = tot[j] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) dot[j] <= shf[j][DOT_W-1:0];
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      mag[j] = dot[j][DOT_W-1] ? (~dot[j] + DOT_W'(1)) : dot[j];
    end
    near = mag[3] <= DOT_W'(near_zero_threshold);
    q_data.do_div = divide_enable && !near;
    q_data.near   = divide_enable && near;
    q_data.den    = mag[3];
    for (int j = 0; j < 3; j++) begin
      q_data.neg[j]   = dot[j][DOT_W-1] ^ dot[3][DOT_W-1];
      q_data.plain[j] = sat_dot(dot[j]);
      q_data.num[j]   = mag[j];
    end
  end

endmodule

### sv/vtp_fifo.sv
// small queue between classification and the divider
module vtp_fifo
  import vtp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t wr_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output qent_t rd_data
);

  qent_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = count == (QPTR_W+1)'(QDEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> !empty)
    else $error("queue lost an entry");

endmodule

### sv/vtp_back.sv
// back end: pipelined restoring divider, one quotient bit per stage, three lanes
module vtp_back
  import vtp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  qent_t     q_data,
  output logic      q_pop,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  localparam int NQ = QUO_W;

  logic                   en;
  logic [NQ:0]            st_v;
  qent_t                  st_ent [NQ+1];
  logic [2:0]             st_ovf [NQ+1];
  logic [2:0][DOT_W-1:0]  st_r   [NQ+1];
  logic [2:0][NQ-1:0]     st_q   [NQ+1];
  logic [2:0][DOT_W-1:0]  r0;
  logic [2:0]             ovf0;
  logic [2:0][31:0]       res;
  logic [2:0][NQ-1:0]     qr;

  assign en    = !result_valid || result_ready;
  assign q_pop = en && q_valid;

  // integer part overflows when the high numerator bits already reach the divisor
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      r0[l]   = q_data.num[l] >> (32 - FRAC_BITS);
      ovf0[l] = r0[l] >= q_data.den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) st_v <= '0;
    else if (en) st_v <= {st_v[NQ-1:0], q_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_ent[0] <= q_data;
      st_ovf[0] <= ovf0;
      st_r[0]   <= r0;
      st_q[0]   <= '0;
    end
  end

  for (genvar s = 0; s < NQ; s++) begin : g_stage
    localparam int NB  = NQ - 1 - s - FRAC_BITS - 1;
    localparam int NBI = (NB >= 0) ? NB : 0;
    logic [2:0][DOT_W-1:0] r_next;
    logic [2:0][NQ-1:0]    q_next;
    logic [DOT_W:0]        r2;
    logic                  take;
    logic                  nbit;

    always_comb begin
      r_next = '0;
      q_next = '0;
      r2     = '0;
      take   = 1'b0;
      nbit   = 1'b0;
      for (int l = 0; l < 3; l++) begin
        nbit      = (NB >= 0) ? st_ent[s].num[l][NBI] : 1'b0;
        r2        = {st_r[s][l], nbit};
        take      = r2 >= {1'b0, st_ent[s].den};
        r_next[l] = take ? DOT_W'(r2 - {1'b0, st_ent[s].den}) : r2[DOT_W-1:0];
        q_next[l] = {st_q[s][l][NQ-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_ent[s+1] <= st_ent[s];
        st_ovf[s+1] <= st_ovf[s];
        st_r[s+1]   <= r_next;
        st_q[s+1]   <= q_next;
      end
    end
  end

  // drop the rounding bit with ties away from zero, then sign and saturate
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qr[l] = NQ'((34'(st_q[NQ][l]) + 34'd1) >> 1);
      if (!st_ent[NQ].do_div) begin
        res[l] = st_ent[NQ].plain[l];
      end else if (st_ovf[NQ][l]) begin
        res[l] = st_ent[NQ].neg[l] ? SAT_MIN : SAT_MAX;
      end else if (st_ent[NQ].neg[l]) begin
        res[l] = (qr[l] > NQ'(33'h0_8000_0000)) ? SAT_MIN : (~qr[l][31:0] + 32'd1);
      end else begin
        res[l] = (qr[l] > NQ'(33'h0_7fff_ffff)) ? SAT_MAX : qr[l][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (en) result_valid <= st_v[NQ];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.out_x       <= res[0];
      result.out_y       <= res[1];
      result.out_z       <= res[2];
      result.w_near_zero <= st_ent[NQ].near;
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("divider took an entry from an empty queue");
  a_tail_held: assert property (@(posedge clk) disable iff (rst)
    (st_v[NQ] && !en) |=> st_v[NQ])
    else $error("divider tail dropped while stalled");
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(st_v[NQ]))
    else $error("result appeared without a finished divide");

endmodule

### sv/vertex_transform_persp_divide.sv
// top level: 4x4 homogeneous vertex transform with perspective divide
//
//  channel  | handshake                 | beat
//  ---------+---------------------------+-----------------------------------
//  item     | item_valid / item_ready   | in_item_t: load coefficient or point
//  result   | result_valid/result_ready | out_item_t: x, y, z, near-zero flag
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data (always ready)
//
// one item per cycle sustained while the result is not stalled; a point taken passes
// 3 front stages, the queue, 1 + 33 divider stages and the output register
// the divider pipeline resolves one quotient bit per stage for all three lanes
// reset clears the matrix, the valid chains and the queue; no clearing pass
// a stalled result stalls the divider; the front keeps running until the queue fills
module vertex_transform_persp_divide
  import vtp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  in_item_t         item,
  output logic             result_valid,
  input  logic             result_ready,
  output out_item_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [THR_W-1:0] cfg_data
);

  logic             divide_enable;
  logic [THR_W-1:0] near_zero_threshold;
  logic             q_push, q_full, q_empty, q_pop;
  qent_t            q_wr, q_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      divide_enable       <= 1'b1;
      near_zero_threshold <= THR_W'(66);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DIVIDE_ENABLE:       divide_enable       <= cfg_data[0];
        CFG_NEAR_ZERO_THRESHOLD: near_zero_threshold <= cfg_data;
        default:                 divide_enable       <= divide_enable;
      endcase
    end
  end

  vtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .item_valid          (item_valid),
    .item_ready          (item_ready),
    .item                (item),
    .divide_enable       (divide_enable),
    .near_zero_threshold (near_zero_threshold),
    .q_ready             (!q_full),
    .q_push              (q_push),
    .q_data              (q_wr)
  );

  vtp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  vtp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!q_empty),
    .q_data       (q_rd),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### tb/tb_vertex_transform_persp_divide.sv
// testbench for the 4x4 vertex transform with perspective divide
`timescale 1ns / 100ps

module tb_vertex_transform_persp_divide;
  import vtp_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 40;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  in_item_t item;
  logic result_valid;
  logic result_ready;
  out_item_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [THR_W-1:0] cfg_data;

  vertex_transform_persp_divide #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [31:0] mat [16];
  logic div_en;
  logic [THR_W-1:0] thresh;

  out_item_t expected_points[$];
  int errors;
  int idle_cycles;
  bit no_idle;
  bit hold_off;
  bit done_sending;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [31:0] sat64(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return SAT_MAX;
    if (v < -96'sd2147483648) return SAT_MIN;
    return v[31:0];
  endfunction

  // rounded dot product of column j, ties toward +inf
  function automatic logic signed [95:0] col_dot(input logic signed [31:0] v [4],
                                                  input int j);
    logic signed [95:0] acc;
    acc = 0;
    for (int k = 0; k < 4; k++)
      acc += 96'(v[k]) * 96'(mat[k*4+j]);
    acc += 96'sd1 <<< (FRAC - 1);
    return acc >>> FRAC;
  endfunction

  // x * 2^frac / w, rounded half away from zero, saturated
  function automatic logic signed [31:0] fx_quot(input logic signed [95:0] x,
                                                 input logic signed [95:0] w);
    logic neg;
    logic [95:0] n, d, q;
    neg = (x < 0) != (w < 0);
    n = (x < 0) ? -x : x;
    d = (w < 0) ? -w : w;
    if ((n / d) >= (96'd1 << (32 - FRAC)))
      return neg ? SAT_MIN : SAT_MAX;
    q = ((n << (FRAC + 1)) / d + 1) >> 1;
    return sat64(neg ? -$signed(q) : $signed(q));
  endfunction

  function automatic out_item_t transform_point(input in_item_t it);
    logic signed [31:0] v [4];
    logic signed [95:0] r [3];
    logic signed [95:0] tw;
    logic [95:0] mag;
    out_item_t o;
    v[0] = it.in_x; v[1] = it.in_y; v[2] = it.in_z; v[3] = it.in_w;
    for (int j = 0; j < 3; j++) r[j] = col_dot(v, j);
    o.w_near_zero = 1'b0;
    if (div_en) begin
      tw = col_dot(v, 3);
      mag = (tw < 0) ? -tw : tw;
      if (mag <= 96'(thresh)) o.w_near_zero = 1'b1;
      else for (int j = 0; j < 3; j++) r[j] = fx_quot(r[j], tw);
    end
    o.out_x = sat64(r[0]);
    o.out_y = sat64(r[1]);
    o.out_z = sat64(r[2]);
    return o;
  endfunction

  task automatic idle_step();
    if (!no_idle && $urandom_range(99) < 39) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // valid stays up after a beat is taken; the next call may drop it when idling, and a stop drops it
  task automatic send_item(input in_item_t it, input bit has_exp, input out_item_t exp_o);
    idle_step();
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (it.cmd == CMD_LOAD) begin
      mat[it.coef_index] = it.coef_value;
    end else begin
      out_item_t o;
      o = transform_point(it);
      if (has_exp && o !== exp_o)
        $display("%0t directed table disagrees: expected %h predicted %h", $time, exp_o, o);
      expected_points.push_back(has_exp ? exp_o : o);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [THR_W-1:0] val);
    item_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_DIVIDE_ENABLE) div_en = val[0];
    else thresh = val;
  endtask

  function automatic in_item_t load_beat(input logic [3:0] idx, input logic signed [31:0] v);
    in_item_t it;
    it = '0;
    it.cmd = CMD_LOAD;
    it.coef_index = idx;
    it.coef_value = v;
    it.in_x = $urandom; it.in_y = $urandom; it.in_z = $urandom; it.in_w = $urandom;
    return it;
  endfunction

  function automatic in_item_t point_beat(input logic signed [31:0] x, y, z, w);
    in_item_t it;
    it.cmd = CMD_POINT;
    it.coef_index = 4'($urandom);
    it.coef_value = $urandom;
    it.in_x = x; it.in_y = y; it.in_z = z; it.in_w = w;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
      default: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
    endcase
  endfunction

  task automatic load_identity_like();
    for (int i = 0; i < 16; i++)
      send_item(load_beat(i[3:0], (i % 5 == 0) ? 32'sh0001_0000 :
                $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000), 0, '0);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8)
        send_item(load_beat(4'($urandom), rand_coord()), 0, '0);
      else
        send_item(point_beat(rand_coord(), rand_coord(), rand_coord(),
                  ($urandom_range(3) == 0) ? rand_coord() : 32'sh0001_0000), 0, '0);
    end
  endtask

  // directed table
  typedef struct {
    in_item_t beat;
    bit has_exp;
    out_item_t exp_o;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(input in_item_t b, input bit h, input out_item_t e);
    dir_row_t r;
    r.beat = b; r.has_exp = h; r.exp_o = e;
    dir_rows.push_back(r);
  endtask

  // receiver
  initial begin
    int hold;
    result_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        result_ready <= 1'b0;
        hold = 300;
        repeat (hold) @(posedge clk);
        hold_off = 1'b0;
      end
      result_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 28);
    end
  end

  // checker
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, result);
        errors++;
      end else begin
        out_item_t e;
        e = expected_points.pop_front();
        if (result.out_x !== e.out_x) begin
          $display("%0t out_x: expected %h actual %h", $time, e.out_x, result.out_x);
          errors++;
        end
        if (result.out_y !== e.out_y) begin
          $display("%0t out_y: expected %h actual %h", $time, e.out_y, result.out_y);
          errors++;
        end
        if (result.out_z !== e.out_z) begin
          $display("%0t out_z: expected %h actual %h", $time, e.out_z, result.out_z);
          errors++;
        end
        if (result.w_near_zero !== e.w_near_zero) begin
          $display("%0t w_near_zero: expected %b actual %b", $time, e.w_near_zero,
                   result.w_near_zero);
          errors++;
        end
      end
    end
  end

  // watchdog on beats that make no progress
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    out_item_t zero_o, sat_o;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DIVIDE_ENABLE;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    hold_off = 1'b0;
    for (int i = 0; i < 16; i++) mat[i] = '0;
    div_en = 1'b1;
    thresh = 17'd66;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero matrix after reset: w is zero so the divide is skipped and flagged
    zero_o = '0;
    zero_o.w_near_zero = 1'b1;
    add_row(point_beat(SAT_MAX, SAT_MIN, 32'sh0001_0000, 32'sh0001_0000), 1, zero_o);
    add_row(point_beat(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1, zero_o);
    // diagonal ones, w column from in_w
    add_row(load_beat(4'd0, 32'sh0001_0000), 0, '0);
    add_row(load_beat(4'd5, 32'sh0001_0000), 0, '0);
    add_row(load_beat(4'd10, 32'sh0001_0000), 0, '0);
    add_row(load_beat(4'd15, 32'sh0001_0000), 0, '0);
    add_row(point_beat(32'sh0002_0000, -32'sh0003_0000, 32'sh0000_8000, 32'sh0002_0000),
            0, '0);
    add_row(point_beat(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sd66), 0, '0);
    add_row(point_beat(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sd67), 0, '0);
    add_row(point_beat(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, -32'sd67), 0, '0);
    // quotient far above range saturates
    sat_o = '0;
    sat_o.out_x = SAT_MAX; sat_o.out_y = SAT_MIN; sat_o.out_z = SAT_MAX;
    add_row(point_beat(SAT_MAX, SAT_MIN, SAT_MAX, 32'sd100), 1, sat_o);
    add_row(load_beat(4'd15, SAT_MIN), 0, '0);
    add_row(load_beat(4'd3, SAT_MAX), 0, '0);
    add_row(point_beat(SAT_MAX, SAT_MIN, 32'sh0001_0000, SAT_MAX), 0, '0);
    add_row(point_beat(SAT_MIN, SAT_MAX, -32'sd1, 32'sd1), 0, '0);

    foreach (dir_rows[i]) send_item(dir_rows[i].beat, dir_rows[i].has_exp,
                                    dir_rows[i].exp_o);

    load_identity_like();
    random_phase(80);

    write_reg(CFG_DIVIDE_ENABLE, 17'd0);
    write_reg(CFG_NEAR_ZERO_THRESHOLD, 17'h1ffff);
    random_phase(60);

    write_reg(CFG_DIVIDE_ENABLE, 17'd1);
    write_reg(CFG_NEAR_ZERO_THRESHOLD, 17'h1ffff);
    random_phase(40);

    write_reg(CFG_NEAR_ZERO_THRESHOLD, 17'd0);
    // long stretch with no idling, receiver held off so the input backs up
    no_idle = 1'b1;
    hold_off = 1'b1;
    random_phase(80);
    no_idle = 1'b0;

    write_reg(CFG_NEAR_ZERO_THRESHOLD, 17'd65536);
    load_identity_like();
    random_phase(60);

    write_reg(CFG_NEAR_ZERO_THRESHOLD, 17'd66);
    random_phase(60);

    item_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### vertex_transform_persp_divide.f
sv/vtp_pkg.sv
sv/vtp_front.sv
sv/vtp_fifo.sv
sv/vtp_back.sv
sv/vertex_transform_persp_divide.sv
tb/tb_vertex_transform_persp_divide.sv
